>>> sv/res_pkg.sv
// Package with the shared types and constants of the row edge search block.
package res_pkg;

    localparam int COL_W         = 9;
    localparam int ROW_WIDTH_DEF = 320;
    localparam int CFG_IDX_W     = 1;

    localparam logic [COL_W-1:0] SCAN_LOW_RST  = COL_W'(10);
    localparam logic [COL_W-1:0] SCAN_HIGH_RST = COL_W'(310);

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_HIGH = CFG_IDX_W'(1);

    typedef struct packed {
        logic             pixel;
        logic [COL_W-1:0] start_col;
        logic             row_end;
    } in_t;

    typedef struct packed {
        logic [COL_W-1:0] right_edge;
        logic [COL_W-1:0] left_edge;
        logic             right_found;
        logic             left_found;
    } out_t;

    typedef struct packed {
        logic [COL_W-1:0] scan_low;
        logic [COL_W-1:0] scan_high;
    } cfg_t;

endpackage

>>> sv/res_scan.sv
// Row state and edge search logic that works on one pixel per accepted transaction.
module res_scan #(
    parameter int ROW_WIDTH = res_pkg::ROW_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  res_pkg::in_t item,
    input  res_pkg::cfg_t cfg,
    output logic         emit,
    output res_pkg::out_t result
);
    import res_pkg::*;

    localparam int CNT_W = $clog2(ROW_WIDTH + 1);
    localparam int CMP_W = ((CNT_W > COL_W) ? CNT_W : COL_W) + 1;
    localparam logic [CNT_W-1:0] ROW_END_COL = CNT_W'(ROW_WIDTH);
    localparam logic [CMP_W-1:0] ONE_C       = CMP_W'(1);
    localparam logic [CMP_W-1:0] THREE_C     = CMP_W'(3);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [2:0]       win_reg, win_next;
    logic [COL_W-1:0] right_hit_reg, right_hit_next;
    logic             right_seen_reg, right_seen_next;
    logic [COL_W-1:0] left_hit_reg, left_hit_next;
    logic             left_seen_reg, left_seen_next;

    logic             in_row;
    logic [2:0]       win_upd;
    logic [CMP_W-1:0] k_ext, k_m3, k_p1, start_ext, low_ext, high_ext;
    logic             r_cand, l_cand;
    logic             r_seen_now, l_seen_now;
    logic [COL_W-1:0] r_hit_now, l_hit_now;

    always_comb
    begin
        in_row    = col_reg < ROW_END_COL;
        win_upd   = {win_reg[1:0], item.pixel};
        k_ext     = CMP_W'(col_reg);
        k_m3      = k_ext - THREE_C;
        k_p1      = k_ext + ONE_C;
        start_ext = CMP_W'(item.start_col);
        low_ext   = CMP_W'(cfg.scan_low);
        high_ext  = CMP_W'(cfg.scan_high);

        r_cand = in_row && (win_upd == 3'b111) && !right_seen_reg && (k_ext >= THREE_C)
                 && (k_m3 >= start_ext) && (k_m3 < high_ext);
        l_cand = in_row && (win_upd == 3'b111) && (k_p1 <= start_ext) && (k_p1 > low_ext);

        r_seen_now = right_seen_reg | r_cand;
        r_hit_now  = r_cand ? k_m3[COL_W-1:0] : right_hit_reg;
        l_seen_now = left_seen_reg | l_cand;
        l_hit_now  = l_cand ? k_p1[COL_W-1:0] : left_hit_reg;

        emit = fire && item.row_end;

        result.right_found = r_seen_now;
        result.left_found  = l_seen_now;
        if (r_seen_now)
        begin
            result.right_edge = r_hit_now;
        end
        else
        begin
            result.right_edge = (item.start_col >= cfg.scan_high) ? item.start_col
                                                                  : cfg.scan_high;
        end
        if (l_seen_now)
        begin
            result.left_edge = l_hit_now;
        end
        else
        begin
            result.left_edge = (item.start_col <= cfg.scan_low) ? item.start_col
                                                                : cfg.scan_low;
        end

        col_next        = col_reg;
        win_next        = win_reg;
        right_hit_next  = right_hit_reg;
        right_seen_next = right_seen_reg;
        left_hit_next   = left_hit_reg;
        left_seen_next  = left_seen_reg;
        if (fire)
        begin
            if (item.row_end)
            begin
                col_next        = '0;
                win_next        = '0;
                right_hit_next  = '0;
                right_seen_next = 1'b0;
                left_hit_next   = '0;
                left_seen_next  = 1'b0;
            end
            else if (in_row)
            begin
                col_next        = col_reg + CNT_W'(1);
                win_next        = win_upd;
                right_hit_next  = r_hit_now;
                right_seen_next = r_seen_now;
                left_hit_next   = l_hit_now;
                left_seen_next  = l_seen_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            win_reg        <= '0;
            right_hit_reg  <= '0;
            right_seen_reg <= 1'b0;
            left_hit_reg   <= '0;
            left_seen_reg  <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            win_reg        <= win_next;
            right_hit_reg  <= right_hit_next;
            right_seen_reg <= right_seen_next;
            left_hit_reg   <= left_hit_next;
            left_seen_reg  <= left_seen_next;
        end
    end

endmodule

>>> sv/row_edge_search_top.sv
// Top level of the row edge search block: configuration registers and result register.
// The block takes one pixel transaction per clock and finds, for each image row, the
// first column right of the start column and the last column left of it that border
// three set pixels, limited by scan_low and scan_high. The result of a row appears in
// the output register in the cycle after its last pixel is accepted, and input is held
// off only while that result register is full and stalled.
module row_edge_search_top #(
    parameter int ROW_WIDTH = res_pkg::ROW_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  res_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output res_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [res_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [res_pkg::COL_W-1:0]        cfg_data
);
    import res_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;
    logic fire, emit;
    out_t result;

    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    res_scan #(
        .ROW_WIDTH(ROW_WIDTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_data),
        .cfg   (cfg_reg),
        .emit  (emit),
        .result(result)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCAN_LOW:  cfg_next.scan_low  = cfg_data;
                REG_SCAN_HIGH: cfg_next.scan_high = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_low  <= SCAN_LOW_RST;
            cfg_reg.scan_high <= SCAN_HIGH_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

>>> sv/res_checker.sv
// Port-level checker for the row edge search top level, with its bind statement.
module res_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input res_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input res_pkg::out_t out_data
);
    import res_pkg::*;

    // A transaction that ends a row always leaves a result waiting in the next cycle.
    a_row_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.row_end |=> out_valid)
        else $error("row end accepted without a result");

    // A result only appears after a row end transaction.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_data.row_end))
        else $error("result without a row end");

    // A stalled result blocks the input side.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind row_edge_search_top res_checker u_res_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
